// ===== src/fst_pkg.sv =====
// Shared types and constants for the frame sequence timer.
`timescale 1ns / 1ps

package fst_pkg;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_FRAME   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAST_FRAME    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_TICKS   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOOP_ENABLE   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOUNCE_ENABLE = 3'd4;

  typedef struct packed {
    logic capture;
    logic load;
    logic begin_adv;
    logic step;
    logic wrap_up;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic skip;
    logic step_due;
    logic out_free;
  } stat_t;

endpackage

// ===== src/fst_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps

module fst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fst_pkg::stat_t st_i,
  output fst_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_STEP,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = ST_NORM;
        end
      end
      ST_NORM: begin
        if (st_i.is_load) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_FIN;
        end else if (st_i.skip) begin
          state_nxt = ST_FIN;
        end else begin
          cmd_o.begin_adv = 1'b1;
          state_nxt       = ST_STEP;
        end
      end
      ST_STEP: begin
        // One frame step per cycle until the accumulator holds less than a frame.
        if (st_i.step_due) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.wrap_up = 1'b1;
          state_nxt     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |-> st_i.out_free)
    else $error("result written while output register is still occupied");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !st_i.out_free) |=> (state_r == ST_FIN))
    else $error("finished item left before its result was written");

endmodule

// ===== src/fst_dp.sv =====
// Datapath: configuration registers, sequencer state, frame stepper and result register.
`timescale 1ns / 1ps

module fst_dp #(
  parameter int FRAME_WIDTH = 16,
  parameter int TICK_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fst_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fst_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                in_action,
  input  logic [TICK_WIDTH-1:0]               in_elapsed,
  input  logic [FRAME_WIDTH-1:0]              in_load_frame,
  input  logic                                in_load_reverse,
  input  logic                                in_load_playing,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [FRAME_WIDTH-1:0]              out_shown_frame,
  output logic                                out_is_playing,
  output logic                                out_is_reverse,
  input  fst_pkg::cmd_t                       cmd_i,
  output fst_pkg::stat_t                      st_o
);

  localparam int ACC_WIDTH = TICK_WIDTH + 1;

  // Configuration registers.
  logic [FRAME_WIDTH-1:0] first_r;
  logic [FRAME_WIDTH-1:0] last_r;
  logic [TICK_WIDTH-1:0]  ticks_r;
  logic                   loop_r;
  logic                   bounce_r;

  // Captured item.
  logic                   act_r;
  logic [TICK_WIDTH-1:0]  elapsed_r;
  logic [FRAME_WIDTH-1:0] lframe_r;
  logic                   lrev_r;
  logic                   lplay_r;

  // Sequencer state.
  logic [FRAME_WIDTH-1:0] frame_r, frame_nxt;
  logic [ACC_WIDTH-1:0]   acc_r, acc_nxt;
  logic                   rev_r, rev_nxt;
  logic                   play_r, play_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [FRAME_WIDTH-1:0] shown_r;
  logic                   oplay_r;
  logic                   orev_r;

  logic [FRAME_WIDTH-1:0] lo_w;
  logic [FRAME_WIDTH-1:0] hi_w;
  logic [TICK_WIDTH-1:0]  dur_w;
  logic                   bounce_w;
  logic                   one_shot_w;
  logic                   outside_w;
  logic [ACC_WIDTH-1:0]   acc_base_w;

  assign lo_w       = first_r;
  assign hi_w       = (last_r < first_r) ? first_r : last_r;
  assign dur_w      = (ticks_r == '0) ? TICK_WIDTH'(1) : ticks_r;
  // Reflection only makes sense when the range holds more than one frame.
  assign bounce_w   = bounce_r && (hi_w > lo_w);
  assign one_shot_w = !loop_r && !bounce_r;
  assign outside_w  = (frame_r < lo_w) || (frame_r > hi_w);
  assign acc_base_w = outside_w ? '0 : acc_r;

  assign st_o.is_load  = act_r;
  assign st_o.skip     = (elapsed_r == '0) || !play_r;
  assign st_o.step_due = (acc_r >= {1'b0, dur_w});
  assign st_o.out_free = !out_valid_r || !out_stall;

  always_comb begin
    frame_nxt = frame_r;
    acc_nxt   = acc_r;
    rev_nxt   = rev_r;
    play_nxt  = play_r;
    if (cmd_i.load) begin
      frame_nxt = lframe_r;
      rev_nxt   = lrev_r;
      play_nxt  = lplay_r;
      acc_nxt   = '0;
    end else if (cmd_i.begin_adv) begin
      // A frame outside the range restarts at the first frame.
      frame_nxt = outside_w ? lo_w : frame_r;
      acc_nxt   = ACC_WIDTH'(acc_base_w + {1'b0, elapsed_r});
    end else if (cmd_i.step) begin
      acc_nxt = acc_r - {1'b0, dur_w};
      if (!rev_r) begin
        if (frame_r == hi_w) begin
          if (bounce_w) begin
            frame_nxt = hi_w - FRAME_WIDTH'(1);
            rev_nxt   = 1'b1;
          end else if (loop_r) begin
            frame_nxt = lo_w;
          end else begin
            frame_nxt = hi_w;
            play_nxt  = 1'b0;
            acc_nxt   = '0;
          end
        end else begin
          frame_nxt = frame_r + FRAME_WIDTH'(1);
        end
      end else begin
        if (frame_r == lo_w) begin
          if (bounce_w) begin
            frame_nxt = lo_w + FRAME_WIDTH'(1);
            rev_nxt   = 1'b0;
          end else if (loop_r) begin
            frame_nxt = hi_w;
          end else begin
            frame_nxt = lo_w;
            play_nxt  = 1'b0;
            acc_nxt   = '0;
          end
        end else begin
          frame_nxt = frame_r - FRAME_WIDTH'(1);
        end
      end
    end else if (cmd_i.wrap_up) begin
      // In one-shot mode, sitting on the end in the direction of play finishes at once.
      if (one_shot_w && ((!rev_r && frame_r == hi_w) || (rev_r && frame_r == lo_w))) begin
        play_nxt = 1'b0;
        acc_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      last_r      <= '0;
      ticks_r     <= TICK_WIDTH'(1);
      loop_r      <= 1'b0;
      bounce_r    <= 1'b0;
      frame_r     <= '0;
      acc_r       <= '0;
      rev_r       <= 1'b0;
      play_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fst_pkg::REG_FIRST_FRAME:   first_r  <= cfg_data[FRAME_WIDTH-1:0];
          fst_pkg::REG_LAST_FRAME:    last_r   <= cfg_data[FRAME_WIDTH-1:0];
          fst_pkg::REG_FRAME_TICKS:   ticks_r  <= cfg_data[TICK_WIDTH-1:0];
          fst_pkg::REG_LOOP_ENABLE:   loop_r   <= cfg_data[0];
          fst_pkg::REG_BOUNCE_ENABLE: bounce_r <= cfg_data[0];
          default: ;
        endcase
      end
      frame_r <= frame_nxt;
      acc_r   <= acc_nxt;
      rev_r   <= rev_nxt;
      play_r  <= play_nxt;
      if (cmd_i.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      act_r     <= in_action;
      elapsed_r <= in_elapsed;
      lframe_r  <= in_load_frame;
      lrev_r    <= in_load_reverse;
      lplay_r   <= in_load_playing;
    end
    if (cmd_i.emit) begin
      shown_r <= frame_r;
      oplay_r <= play_r;
      orev_r  <= rev_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shown_frame = shown_r;
  assign out_is_playing  = oplay_r;
  assign out_is_reverse  = orev_r;

  a_step_only_playing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.step |-> play_r)
    else $error("frame step issued while the animation is stopped");

  a_load_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load |=> (acc_r == '0))
    else $error("load item did not clear the tick accumulator");

endmodule

// ===== src/frame_sequence_timer_core.sv =====
// Top level of the frame sequence timer: controller plus datapath.
`timescale 1ns / 1ps

// Frame sequencer for a display animation. Each item either loads frame, direction and
// playing flag, or advances time by in_elapsed ticks; every item returns one result with
// the frame to show and the play state. A load, a zero advance or an advance while paused
// goes from the NORM state straight to FIN. An advance passes through the STEP state for up
// to N frame steps, where N is the number of whole frame durations in the carried plus elapsed
// ticks: the datapath moves one frame per cycle, and a one-shot animation stops early at
// its end. A result still waiting in the output register delays the write of the next
// result for as long as it stays stalled. A new item is taken once the previous one has
// reached the result register, so a waiting result does not hold up the next item's work.
// Configuration writes are always ready and must only be issued while no item is in flight.
module frame_sequence_timer_core #(
  parameter int FRAME_WIDTH = 16,
  parameter int TICK_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fst_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fst_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [TICK_WIDTH-1:0]               in_elapsed,
  input  logic [FRAME_WIDTH-1:0]              in_load_frame,
  input  logic                                in_load_reverse,
  input  logic                                in_load_playing,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [FRAME_WIDTH-1:0]              out_shown_frame,
  output logic                                out_is_playing,
  output logic                                out_is_reverse
);

  fst_pkg::cmd_t  cmd;
  fst_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  fst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st_i     (stat),
    .cmd_o    (cmd)
  );

  fst_dp #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_elapsed      (in_elapsed),
    .in_load_frame   (in_load_frame),
    .in_load_reverse (in_load_reverse),
    .in_load_playing (in_load_playing),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_shown_frame (out_shown_frame),
    .out_is_playing  (out_is_playing),
    .out_is_reverse  (out_is_reverse),
    .cmd_i           (cmd),
    .st_o            (stat)
  );

endmodule
